[design/assert_macros.svh]
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside of reset
`define AIP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define AIP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/aip_pkg.sv]
// types and constants of the modem reply parser
`default_nettype none

package aip_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 14;
  localparam int STAT_W = 2;

  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 14'd1024;
  localparam logic [LEN_W-1:0] TRAILER_LEN     = 14'd8;

  // request kinds
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_BYTE  = 1'b1;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // status codes
  localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_BAD_TERM  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_TOO_LARGE = 2'd2;

  // characters of the reply
  localparam logic [BYTE_W-1:0] CH_O     = 8'h4F;
  localparam logic [BYTE_W-1:0] CH_K     = 8'h4B;
  localparam logic [BYTE_W-1:0] CH_D     = 8'h44;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_E     = 8'h45;
  localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_OK_FIND  = 4'd1,
    PH_OK_CR    = 4'd2,
    PH_OK_LF    = 4'd3,
    PH_D_FIND   = 4'd4,
    PH_LEN      = 4'd5,
    PH_PAYLOAD  = 4'd6,
    PH_TRAILER  = 4'd7,
    PH_ED_FIND  = 4'd8,
    PH_ED_TAIL1 = 4'd9,
    PH_ED_TAIL2 = 4'd10
  } phase_t;

  typedef struct packed {
    logic              req_type;
    logic              mode_is_write;
    logic [BYTE_W-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] payload_byte;
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  payload_len;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

[design/aip_in_stage.sv]
// input register stage of the reply parser
`default_nettype none

module aip_in_stage
  import aip_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_req_type,
  input  wire logic              in_mode_is_write,
  input  wire logic [BYTE_W-1:0] in_rx_byte,
  input  wire logic              advance,
  output logic                   s1_valid,
  output item_t                  s1_item
);

  logic  valid_r;
  item_t item_r;

  assign in_ready = !valid_r || advance;
  assign s1_valid = valid_r;
  assign s1_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.req_type      <= in_req_type;
      item_r.mode_is_write <= in_mode_is_write;
      item_r.rx_byte       <= in_rx_byte;
    end
  end

endmodule

`default_nettype wire

[design/aip_fsm.sv]
// parse state machine: one beat of state update and result per step
`default_nettype none

module aip_fsm
  import aip_pkg::*;
#(
  parameter int LEN_DIGITS = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire item_t            item,
  input  wire logic [LEN_W-1:0] max_payload,
  output logic                  has_res,
  output res_t                  res
);

  localparam int DCNT_W = $clog2(LEN_DIGITS + 1);

  phase_t             phase_r, phase_nxt;
  logic [BYTE_W-1:0]  prev_byte_r, prev_byte_nxt;
  logic               prev_valid_r, prev_valid_nxt;
  logic               write_mode_r, write_mode_nxt;
  logic [LEN_W-1:0]   length_r, length_nxt;
  logic [DCNT_W-1:0]  digit_cnt_r, digit_cnt_nxt;
  logic [LEN_W-1:0]   byte_cnt_r, byte_cnt_nxt;
  logic               bad_cr_r, bad_cr_nxt;

  logic [BYTE_W-1:0]  b;
  logic               is_byte;
  logic [LEN_W-1:0]   byte_inc;
  logic               is_digit;
  logic [LEN_W-1:0]   len_times_ten;

  assign b        = item.rx_byte;
  assign is_byte  = step && (item.req_type == REQ_BYTE);
  assign byte_inc = byte_cnt_r + 1'b1;
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  // x*10 as x*8 + x*2, wraps at the field width
  assign len_times_ten = {length_r[LEN_W-4:0], 3'b000} + {length_r[LEN_W-2:0], 1'b0};

  // next state
  always_comb begin
    phase_nxt      = phase_r;
    prev_byte_nxt  = prev_byte_r;
    prev_valid_nxt = prev_valid_r;
    write_mode_nxt = write_mode_r;
    length_nxt     = length_r;
    digit_cnt_nxt  = digit_cnt_r;
    byte_cnt_nxt   = byte_cnt_r;
    bad_cr_nxt     = bad_cr_r;
    if (step && item.req_type == REQ_START) begin
      write_mode_nxt = item.mode_is_write;
      length_nxt     = '0;
      digit_cnt_nxt  = '0;
      byte_cnt_nxt   = '0;
      bad_cr_nxt     = 1'b0;
      phase_nxt      = PH_OK_FIND;
      prev_byte_nxt  = '0;
      prev_valid_nxt = 1'b0;
    end else if (is_byte) begin
      unique case (phase_r)
        PH_OK_FIND: begin
          prev_byte_nxt  = b;
          prev_valid_nxt = 1'b1;
          if (prev_valid_r && prev_byte_r == CH_O && b == CH_K) begin
            phase_nxt = PH_OK_CR;
          end
        end
        PH_OK_CR: begin
          bad_cr_nxt = (b != CH_CR);
          phase_nxt  = PH_OK_LF;
        end
        PH_OK_LF: begin
          if (bad_cr_r || b != CH_LF) begin
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt      = write_mode_r ? PH_ED_FIND : PH_D_FIND;
            prev_byte_nxt  = '0;
            prev_valid_nxt = 1'b0;
          end
        end
        PH_D_FIND: begin
          prev_byte_nxt  = b;
          prev_valid_nxt = 1'b1;
          if (prev_valid_r && prev_byte_r == CH_D && b == CH_COMMA) begin
            phase_nxt     = PH_LEN;
            length_nxt    = '0;
            digit_cnt_nxt = '0;
          end
        end
        PH_LEN: begin
          if (b == CH_COLON) begin
            byte_cnt_nxt = '0;
            if (length_r > max_payload) begin
              phase_nxt      = PH_ED_FIND;
              prev_byte_nxt  = '0;
              prev_valid_nxt = 1'b0;
            end else begin
              phase_nxt = (length_r == '0) ? PH_TRAILER : PH_PAYLOAD;
            end
          end else if (is_digit && digit_cnt_r < DCNT_W'(LEN_DIGITS)) begin
            length_nxt    = len_times_ten + {{(LEN_W-4){1'b0}}, b[3:0]};
            digit_cnt_nxt = digit_cnt_r + 1'b1;
          end
        end
        PH_PAYLOAD: begin
          if (byte_inc >= length_r) begin
            byte_cnt_nxt = '0;
            phase_nxt    = PH_TRAILER;
          end else begin
            byte_cnt_nxt = byte_inc;
          end
        end
        PH_TRAILER: begin
          if (byte_inc >= TRAILER_LEN) begin
            byte_cnt_nxt = '0;
            phase_nxt    = PH_IDLE;
          end else begin
            byte_cnt_nxt = byte_inc;
          end
        end
        PH_ED_FIND: begin
          prev_byte_nxt  = b;
          prev_valid_nxt = 1'b1;
          if (prev_valid_r && prev_byte_r == CH_E && b == CH_D) begin
            phase_nxt = PH_ED_TAIL1;
          end
        end
        PH_ED_TAIL1: phase_nxt = PH_ED_TAIL2;
        PH_ED_TAIL2: phase_nxt = PH_IDLE;
        default:     phase_nxt = PH_IDLE;
      endcase
    end
  end

  // result of the current beat
  always_comb begin
    has_res          = 1'b0;
    res.kind         = KIND_STATUS;
    res.payload_byte = '0;
    res.status       = STATUS_OK;
    res.payload_len  = length_r;
    res.last         = 1'b1;
    if (is_byte) begin
      unique case (phase_r)
        PH_OK_LF: begin
          if (bad_cr_r || b != CH_LF) begin
            has_res         = 1'b1;
            res.status      = STATUS_BAD_TERM;
            res.payload_len = '0;
          end
        end
        PH_PAYLOAD: begin
          has_res          = 1'b1;
          res.kind         = KIND_PAYLOAD;
          res.payload_byte = b;
          res.last         = 1'b0;
        end
        PH_TRAILER: begin
          has_res = (byte_inc >= TRAILER_LEN);
        end
        PH_ED_TAIL2: begin
          has_res = 1'b1;
          if (write_mode_r) begin
            res.payload_len = '0;
          end else begin
            res.status = STATUS_TOO_LARGE;
          end
        end
        default: has_res = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      prev_byte_r  <= '0;
      prev_valid_r <= 1'b0;
      write_mode_r <= 1'b0;
      length_r     <= '0;
      digit_cnt_r  <= '0;
      byte_cnt_r   <= '0;
      bad_cr_r     <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      prev_byte_r  <= prev_byte_nxt;
      prev_valid_r <= prev_valid_nxt;
      write_mode_r <= write_mode_nxt;
      length_r     <= length_nxt;
      digit_cnt_r  <= digit_cnt_nxt;
      byte_cnt_r   <= byte_cnt_nxt;
      bad_cr_r     <= bad_cr_nxt;
    end
  end

endmodule

`default_nettype wire

[design/aip_out_stage.sv]
// result register of the reply parser
`default_nettype none

module aip_out_stage
  import aip_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  load,
  input  wire logic  load_valid,
  input  wire res_t  load_res,
  output logic       can_take,
  output logic       out_valid,
  input  wire logic  out_ready,
  output res_t       out_res
);

  logic valid_r;
  res_t res_r;

  assign can_take  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= load_valid;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_valid) begin
      res_r <= load_res;
    end
  end

endmodule

`default_nettype wire

[design/at_ipd_response_parser.sv]
// top level: byte-serial parser for a modem data reply
// path: a beat is registered in stage 1, then its result in the result register
// throughput: one beat per cycle while a full result register is not held by out_ready; the
//   combinational state update (with its times-ten length adder) sets the rate
// reset: synchronous active-low rst_n clears parse state, both stage valids,
//   and sets max_payload back to 1024
`default_nettype none

module at_ipd_response_parser
  import aip_pkg::*;
#(
  parameter int LEN_DIGITS = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // request beats
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_req_type,
  input  wire logic              in_mode_is_write,
  input  wire logic [BYTE_W-1:0] in_rx_byte,
  // result beats
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_kind,
  output logic [BYTE_W-1:0]      out_payload_byte,
  output logic [STAT_W-1:0]      out_status,
  output logic [LEN_W-1:0]       out_payload_len,
  output logic                   out_last,
  // max_payload register
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [LEN_W-1:0]  cfg_max_payload
);

  // configuration register, always writable
  logic [LEN_W-1:0] max_payload_r;

  // stage 1 holds the accepted beat; it moves on when the result register
  // is empty or being drained this cycle
  logic  s1_valid;
  item_t s1_item;
  logic  can_take;
  logic  advance;

  // result produced by the parser for the advancing beat
  logic  has_res;
  res_t  fsm_res;
  res_t  out_res;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && can_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_payload_r <= cfg_max_payload;
    end
  end

  aip_in_stage u_in_stage (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_mode_is_write (in_mode_is_write),
    .in_rx_byte       (in_rx_byte),
    .advance          (advance),
    .s1_valid         (s1_valid),
    .s1_item          (s1_item)
  );

  // parse state only changes when a beat advances out of stage 1
  aip_fsm #(
    .LEN_DIGITS (LEN_DIGITS)
  ) u_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .item        (s1_item),
    .max_payload (max_payload_r),
    .has_res     (has_res),
    .res         (fsm_res)
  );

  // beats with no result clear the result register when it drains
  aip_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .load_valid (has_res),
    .load_res   (fsm_res),
    .can_take   (can_take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (out_res)
  );

  assign out_kind         = out_res.kind;
  assign out_payload_byte = out_res.payload_byte;
  assign out_status       = out_res.status;
  assign out_payload_len  = out_res.payload_len;
  assign out_last         = out_res.last;

endmodule

`default_nettype wire

[design/aip_checker.sv]
// port-level checks of the reply parser and their bind
`default_nettype none

`include "assert_macros.svh"

module aip_checker
  import aip_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              out_kind,
  input wire logic [BYTE_W-1:0] out_payload_byte,
  input wire logic [STAT_W-1:0] out_status,
  input wire logic [LEN_W-1:0]  out_payload_len,
  input wire logic              out_last
);

  logic [BYTE_W+STAT_W+LEN_W+1:0] out_beat;
  logic                           pay_beat;
  logic                           bad_beat;

  assign out_beat = {out_kind, out_payload_byte, out_status, out_payload_len, out_last};
  assign pay_beat = out_valid && out_kind == KIND_PAYLOAD;
  assign bad_beat = out_valid && out_status == STATUS_BAD_TERM;

  // a stalled result beat holds
  `AIP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_beat), "beat changed")

  // status beats close the reply, payload beats never do
  `AIP_ASSERT(a_status_last, out_valid |-> (out_kind == KIND_STATUS) == out_last, "last vs kind")

  // payload beats carry no status
  `AIP_ASSERT(a_payload_status, pay_beat |-> out_status == STATUS_OK, "status on payload beat")

  // a bad terminator comes before any length is known
  `AIP_ASSERT(a_bad_term_size, bad_beat |-> out_payload_len == '0, "length on bad terminator")

  // nothing comes out right after reset
  `AIP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind at_ipd_response_parser aip_checker u_aip_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_kind         (out_kind),
  .out_payload_byte (out_payload_byte),
  .out_status       (out_status),
  .out_payload_len  (out_payload_len),
  .out_last         (out_last)
);

`default_nettype wire

[dv/aip_reply_checker.sv]
// checker for the modem reply parser: predicts result beats and compares them
`timescale 1ns / 100ps

module aip_reply_checker
  import aip_pkg::*;
#(
  parameter int LEN_DIGITS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              in_req_type,
  input  logic              in_mode_is_write,
  input  logic [BYTE_W-1:0] in_rx_byte,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              out_kind,
  input  logic [BYTE_W-1:0] out_payload_byte,
  input  logic [STAT_W-1:0] out_status,
  input  logic [LEN_W-1:0]  out_payload_len,
  input  logic              out_last,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [LEN_W-1:0]  cfg_max_payload,
  output int                mismatch_count,
  output int                outstanding
);

  localparam int REPORT_CAP = 50;

  // parser shadow state
  phase_t            ph;
  logic [BYTE_W-1:0] win_prev;
  logic              win_full;
  logic              in_write;
  logic [LEN_W-1:0]  len_acc;
  logic [2:0]        len_digits;
  logic [LEN_W-1:0]  byte_cnt;
  logic              bad_cr;
  logic [LEN_W-1:0]  max_len;

  res_t expected_q[$];
  int   errs = 0;

  initial begin
    mismatch_count = 0;
    outstanding    = 0;
  end

  function automatic void clear_parser();
    ph         = PH_IDLE;
    win_prev   = '0;
    win_full   = 1'b0;
    in_write   = 1'b0;
    len_acc    = '0;
    len_digits = '0;
    byte_cnt   = '0;
    bad_cr     = 1'b0;
  endfunction

  // two-byte sliding window, true when first/second just completed
  function automatic logic window_match(input logic [BYTE_W-1:0] b,
                                        input logic [BYTE_W-1:0] first,
                                        input logic [BYTE_W-1:0] second);
    logic hit;
    hit      = win_full && win_prev == first && b == second;
    win_prev = b;
    win_full = 1'b1;
    return hit;
  endfunction

  function automatic void open_search(input phase_t target);
    ph       = target;
    win_prev = '0;
    win_full = 1'b0;
  endfunction

  function automatic res_t status_beat(input logic [STAT_W-1:0] st,
                                       input logic [LEN_W-1:0] size);
    res_t r;
    r.kind         = KIND_STATUS;
    r.payload_byte = '0;
    r.status       = st;
    r.payload_len  = size;
    r.last         = 1'b1;
    ph             = PH_IDLE;
    return r;
  endfunction

  // advance the shadow parser by one request beat, true when a result is due
  function automatic logic parse_beat(input item_t req, output res_t r);
    logic [BYTE_W-1:0] b;
    logic [31:0]       grown;
    b = req.rx_byte;
    r = '0;
    if (req.req_type == REQ_START) begin
      in_write   = req.mode_is_write;
      len_acc    = '0;
      len_digits = '0;
      byte_cnt   = '0;
      bad_cr     = 1'b0;
      open_search(PH_OK_FIND);
      return 1'b0;
    end
    case (ph)
      PH_OK_FIND: if (window_match(b, CH_O, CH_K)) ph = PH_OK_CR;
      PH_OK_CR: begin
        bad_cr = (b != CH_CR);
        ph     = PH_OK_LF;
      end
      PH_OK_LF: begin
        if (bad_cr || b != CH_LF) begin
          r = status_beat(STATUS_BAD_TERM, '0);
          return 1'b1;
        end
        open_search(in_write ? PH_ED_FIND : PH_D_FIND);
      end
      PH_D_FIND: begin
        if (window_match(b, CH_D, CH_COMMA)) begin
          ph         = PH_LEN;
          len_acc    = '0;
          len_digits = '0;
        end
      end
      PH_LEN: begin
        if (b == CH_COLON) begin
          byte_cnt = '0;
          if (len_acc > max_len) open_search(PH_ED_FIND);
          else ph = (len_acc == '0) ? PH_TRAILER : PH_PAYLOAD;
        end else if (b >= CH_ZERO && b <= CH_NINE && len_digits < LEN_DIGITS) begin
          grown      = len_acc * 10 + (b - CH_ZERO);
          len_acc    = grown[LEN_W-1:0];
          len_digits = len_digits + 3'd1;
        end
      end
      PH_PAYLOAD: begin
        r.kind         = KIND_PAYLOAD;
        r.payload_byte = b;
        r.status       = STATUS_OK;
        r.payload_len  = len_acc;
        r.last         = 1'b0;
        byte_cnt       = byte_cnt + 1'b1;
        if (byte_cnt >= len_acc) begin
          byte_cnt = '0;
          ph       = PH_TRAILER;
        end
        return 1'b1;
      end
      PH_TRAILER: begin
        byte_cnt = byte_cnt + 1'b1;
        if (byte_cnt >= TRAILER_LEN) begin
          byte_cnt = '0;
          r = status_beat(STATUS_OK, len_acc);
          return 1'b1;
        end
      end
      PH_ED_FIND: if (window_match(b, CH_E, CH_D)) ph = PH_ED_TAIL1;
      PH_ED_TAIL1: ph = PH_ED_TAIL2;
      PH_ED_TAIL2: begin
        if (in_write) r = status_beat(STATUS_OK, '0);
        else r = status_beat(STATUS_TOO_LARGE, len_acc);
        return 1'b1;
      end
      default: ph = PH_IDLE;
    endcase
    return 1'b0;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      if (errs < REPORT_CAP)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk) begin
    item_t req;
    res_t  want;
    res_t  predicted;
    if (!rst_n) begin
      clear_parser();
      max_len = MAX_PAYLOAD_RST;
      expected_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          if (errs < REPORT_CAP)
            $display("%0t: result beat, expected none, actual kind %0d byte %0d status %0d",
                     $time, out_kind, out_payload_byte, out_status);
          errs++;
        end else begin
          want = expected_q.pop_front();
          check_field("kind", want.kind, out_kind);
          check_field("payload_byte", want.payload_byte, out_payload_byte);
          check_field("status", want.status, out_status);
          check_field("payload_len", want.payload_len, out_payload_len);
          check_field("last", want.last, out_last);
        end
      end
      if (cfg_valid && cfg_ready) max_len = cfg_max_payload;
      if (in_valid && in_ready) begin
        req.req_type      = in_req_type;
        req.mode_is_write = in_mode_is_write;
        req.rx_byte       = in_rx_byte;
        if (parse_beat(req, predicted)) expected_q.push_back(predicted);
      end
    end
    mismatch_count <= errs;
    outstanding    <= expected_q.size();
  end

endmodule

[dv/tb_at_ipd_response_parser.sv]
// testbench top for the modem reply parser: stimulus, back-pressure and verdict
`timescale 1ns / 100ps

module tb_at_ipd_response_parser;
  import aip_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int DRAIN_CYCLES   = 6;    // result passes stage 1 and the result register after its beat is taken
  localparam int HOLD_CYCLES    = 400;  // long receiver hold-off
  localparam int ITEMS_PER_STEP = 90;
  localparam int NUM_STEPS      = 12;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_req_type = REQ_BYTE;
  logic              in_mode_is_write = 1'b0;
  logic [BYTE_W-1:0] in_rx_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_kind;
  logic [BYTE_W-1:0] out_payload_byte;
  logic [STAT_W-1:0] out_status;
  logic [LEN_W-1:0]  out_payload_len;
  logic              out_last;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [LEN_W-1:0]  cfg_max_payload = '0;

  int mismatches;
  int outstanding;

  // idle percentages for each side, changed per phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // receiver hold-off handshake: toggling stall_req starts one long hold
  logic stall_req = 1'b0;
  logic stall_ack = 1'b0;
  int   stall_left = 0;

  int cycle_count = 0;
  int items_sent = 0;
  int cut_left = -1;   // bytes left before a reply is abandoned, -1 when whole
  int cur_max = MAX_PAYLOAD_RST;

  at_ipd_response_parser u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_mode_is_write(in_mode_is_write),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_payload_byte(out_payload_byte),
    .out_status      (out_status),
    .out_payload_len (out_payload_len),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_max_payload (cfg_max_payload)
  );

  aip_reply_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_mode_is_write(in_mode_is_write),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_payload_byte(out_payload_byte),
    .out_status      (out_status),
    .out_payload_len (out_payload_len),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_max_payload (cfg_max_payload),
    .mismatch_count  (mismatches),
    .outstanding     (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random ready, or a long hold-off counted here
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_req != stall_ack) begin
      stall_ack  <= stall_req;
      stall_left <= HOLD_CYCLES;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // one request beat; valid only drops while idling, after the previous beat went through
  task automatic send_beat(input logic req, input logic mode, input logic [BYTE_W-1:0] b);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_req_type      <= req;
    in_mode_is_write <= mode;
    in_rx_byte       <= b;
    items_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  // received byte inside a reply; stops sending once an abandoned reply runs out
  task automatic put_byte(input logic [BYTE_W-1:0] b);
    if (cut_left == 0) return;
    if (cut_left > 0) cut_left--;
    send_beat(REQ_BYTE, 1'($urandom_range(0, 1)), b);
  endtask

  task automatic put_noise(input int n);
    repeat (n) put_byte(8'($urandom_range(0, 255)));
  endtask

  // stop offering, wait for every expected result, then let the pipe empty
  task automatic settle();
    @(negedge clk) in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input int v);
    @(negedge clk);
    cfg_valid       <= 1'b1;
    cfg_max_payload <= LEN_W'(v);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid <= 1'b0;
    cur_max = v;
  endtask

  // one reply: start beat, OK + terminator (sometimes bad, which ends it), then the write tail or the read body
  task automatic send_reply(input logic mode, input int forced_len);
    int len;
    int nd;
    int width;
    int pw;
    int roll;
    logic [BYTE_W-1:0] junk;
    cut_left = (forced_len < 0 && $urandom_range(0, 99) < 8) ? $urandom_range(1, 20) : -1;
    send_beat(REQ_START, mode, 8'($urandom_range(0, 255)));
    put_noise($urandom_range(0, 3));
    put_byte(CH_O);
    put_byte(CH_K);
    roll = (forced_len < 0) ? $urandom_range(0, 99) : 99;
    if (roll < 5) begin
      // wrong CR, then LF or anything
      junk = 8'($urandom_range(0, 255));
      if (junk == CH_CR) junk = ~junk;
      put_byte(junk);
      put_byte($urandom_range(0, 1) ? CH_LF : 8'($urandom_range(0, 255)));
      return;
    end
    put_byte(CH_CR);
    if (roll < 10) begin
      // right CR, wrong LF
      junk = 8'($urandom_range(0, 255));
      if (junk == CH_LF) junk = ~junk;
      put_byte(junk);
      return;
    end
    put_byte(CH_LF);
    if (mode) begin
      put_noise($urandom_range(0, 4));
      put_byte(CH_E);
      put_byte(CH_D);
      put_noise(2);
      return;
    end
    put_noise($urandom_range(0, 3));
    put_byte(CH_D);
    put_byte(CH_COMMA);

    // mostly small payloads, a few big ones, some over the limit
    if (forced_len >= 0) len = forced_len;
    else begin
      roll = $urandom_range(0, 99);
      if (roll < 5) len = 0;
      else if (roll < 65) len = $urandom_range(1, 12);
      else if (roll < 80) len = $urandom_range(13, 99);
      else if (roll < 84) len = $urandom_range(100, 300);
      else if (cur_max < 9999) len = $urandom_range(cur_max + 1, 9999);
      else len = $urandom_range(1, 12);
    end

    // decimal length, sometimes with leading zeros and stray non-digits
    nd = 1;
    pw = 10;
    while (pw <= len) begin
      nd++;
      pw *= 10;
    end
    width = $urandom_range(nd, 4);
    pw = 1;
    repeat (width - 1) pw *= 10;
    while (pw > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        junk = 8'($urandom_range(0, 255));
        if ((junk >= CH_ZERO && junk <= CH_NINE) || junk == CH_COLON) junk ^= 8'h40;
        put_byte(junk);
      end
      put_byte(8'(CH_ZERO + (len / pw) % 10));
      pw /= 10;
    end
    // digits past the fourth are dropped by the parser
    if (width == 4 && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2)) put_byte(8'(CH_ZERO + $urandom_range(0, 9)));
    put_byte(CH_COLON);

    if (len > cur_max) begin
      put_noise($urandom_range(0, 4));
      put_byte(CH_E);
      put_byte(CH_D);
      put_noise(2);
    end else begin
      put_noise(len);  // payload
      put_noise(8);    // trailer
    end
  endtask

  initial begin
    int step_base;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: bytes while idle, a clean write reply, a bad LF after OK
    send_beat(REQ_BYTE, 1'b1, 8'hFF);
    send_beat(REQ_BYTE, 1'b0, 8'h00);
    send_beat(REQ_START, 1'b1, 8'hFF);
    put_byte(CH_O);
    put_byte(CH_K);
    put_byte(CH_CR);
    put_byte(CH_LF);
    put_byte(CH_E);
    put_byte(CH_D);
    put_byte(8'h00);
    put_byte(8'hFF);
    send_beat(REQ_START, 1'b0, 8'h00);
    put_byte(CH_O);
    put_byte(CH_K);
    put_byte(CH_CR);
    put_byte(8'h78);

    for (int stage_idx = 0; stage_idx < NUM_STEPS; stage_idx++) begin
      settle();
      // idling phases: sender light / receiver heavy, then swapped, then none
      case (stage_idx / 4)
        0: begin
          send_idle_pct = 21;
          recv_idle_pct = 72;
        end
        1: begin
          send_idle_pct = 72;
          recv_idle_pct = 21;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      // max_payload sweep, reset value kept for the first stretch
      case (stage_idx)
        0: ;
        1: cfg_write(0);
        2: cfg_write(9999);
        3: cfg_write($urandom_range(0, 9999));
        4: cfg_write(1);
        5: cfg_write($urandom_range(0, 63));
        6: cfg_write($urandom_range(0, 9999));
        7: cfg_write(16);
        8: cfg_write(9999);
        9: cfg_write($urandom_range(0, 9999));
        10: cfg_write($urandom_range(0, 255));
        default: cfg_write(MAX_PAYLOAD_RST);
      endcase
      if (stage_idx == 8) begin
        // long hold-off while a payload reply keeps coming, fills the block
        stall_req <= ~stall_req;
        send_reply(1'b0, 60);
      end
      step_base = items_sent;
      while (items_sent - step_base < ITEMS_PER_STEP) begin
        if ($urandom_range(0, 99) < 85) begin
          send_reply($urandom_range(0, 2) == 0, -1);
        end else begin
          // stray beats: bytes while idle, restarts mid-reply
          repeat ($urandom_range(1, 4))
            send_beat($urandom_range(0, 3) == 0 ? REQ_START : REQ_BYTE,
                      1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end
      end
    end

    settle();
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
